// ===== rtl/dqdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqdm_pkg: shared types and codes for the deque with delete-min
// Request and response payloads, operation and status codes, controller
// states, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dqdm_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PREPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL_MIN = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [TOTAL_W-1:0]        entry_total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic                accept;
      logic                insert;
      logic                scan_start;
      logic                scan_step;
      logic                shift_rd;
      logic                shift_wr;
      logic                remove;
      logic                pend_load;
      logic                use_best;
      logic [STATUS_W-1:0] status;
      logic                deliver;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              empty;
      logic              scan_more;
      logic              shift_more;
      logic              out_free;
   } sts_type;

endpackage

// ===== rtl/dqdm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqdm_dpath: entry memory, pointers and result registers
// Entries live in a circular buffer; the head pointer moves on prepend, the
// minimum is found by a read sweep and the gap is closed entry by entry.
// ----------------------------------------------------------------------------
module dqdm_dpath import dqdm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int AW1 = AW + 1;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(CAPACITY - 1);
   localparam logic [AW:0]    CAP_WIDE  = AW1'(CAPACITY);
   localparam logic [CW-1:0]  CAP_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0]  ONE_COUNT = CW'(1);

   // logical offset from the front to a physical memory address
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_WIDE) begin
         sum = sum - CAP_WIDE;
      end
      return sum[AW-1:0];
   endfunction

   logic signed [VALUE_W-1:0] mem [CAPACITY];

   logic [AW-1:0]             head_ff, head_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             rd_off_ff, rd_off_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic signed [VALUE_W-1:0] best_ff, best_in;
   logic [FUNC_W-1:0]         func_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [STATUS_W-1:0]       pend_status_ff;
   logic signed [VALUE_W-1:0] pend_removed_ff;
   logic [TOTAL_W-1:0]        pend_total_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_payload_ff;

   logic                      rd_en, wr_en;
   logic [AW-1:0]             rd_off, rd_addr, wr_addr, head_dec;
   logic signed [VALUE_W-1:0] wr_data;
   logic [CW-1:0]             idx_inc;

   always_comb begin
      head_dec  = (head_ff == '0) ? LAST_ADDR : head_ff - AW'(1);
      idx_inc   = idx_ff + ONE_COUNT;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      rd_off_in = rd_off_ff;
      pos_in    = pos_ff;
      best_in   = best_ff;
      rd_en     = 1'b0;
      rd_off    = '0;
      wr_en     = 1'b0;
      wr_addr   = phys(head_ff, idx_ff[AW-1:0]);
      wr_data   = rd_data_ff;

      if (cmd.insert) begin
         wr_en    = 1'b1;
         wr_data  = value_ff;
         count_in = count_ff + ONE_COUNT;
         if (func_ff == FUNC_PREPEND) begin
            wr_addr = head_dec;
            head_in = head_dec;
         end else begin
            wr_addr = phys(head_ff, count_ff[AW-1:0]);
         end
      end

      if (cmd.scan_start) begin
         rd_en     = 1'b1;
         rd_off    = '0;
         rd_off_in = '0;
         idx_in    = ONE_COUNT;
      end

      if (cmd.scan_step) begin
         // strict compare keeps the occurrence nearest the front
         if (rd_off_ff == '0 || rd_data_ff < best_ff) begin
            best_in = rd_data_ff;
            pos_in  = rd_off_ff;
         end
         if (idx_ff < count_ff) begin
            rd_en     = 1'b1;
            rd_off    = idx_ff[AW-1:0];
            rd_off_in = idx_ff[AW-1:0];
            idx_in    = idx_inc;
         end else begin
            idx_in = CW'(pos_in);
         end
      end

      if (cmd.shift_rd) begin
         rd_en  = 1'b1;
         rd_off = idx_inc[AW-1:0];
      end

      if (cmd.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, idx_ff[AW-1:0]);
         wr_data = rd_data_ff;
         idx_in  = idx_inc;
      end

      if (cmd.remove) begin
         count_in = count_ff - ONE_COUNT;
      end

      rd_addr = phys(head_ff, rd_off);

      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      sts.func       = func_ff;
      sts.full       = (count_ff == CAP_COUNT);
      sts.empty      = (count_ff == '0);
      sts.scan_more  = (idx_ff < count_ff);
      sts.shift_more = (idx_inc < count_ff);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_off_ff <= rd_off_in;
      pos_ff    <= pos_in;
      best_ff   <= best_in;
      if (cmd.accept) begin
         func_ff  <= req_payload.func;
         value_ff <= req_payload.value;
      end
      if (cmd.pend_load) begin
         pend_status_ff  <= cmd.status;
         pend_removed_ff <= cmd.use_best ? best_ff : '0;
         pend_total_ff   <= TOTAL_W'(count_in);
      end
      if (cmd.deliver) begin
         rsp_payload_ff.status        <= pend_status_ff;
         rsp_payload_ff.removed_value <= pend_removed_ff;
         rsp_payload_ff.entry_total   <= pend_total_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/dqdm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqdm_ctrl: operation sequencer
// Takes a request, runs the insert or the delete-min sweep on the datapath
// and hands the result to the response register.
// ----------------------------------------------------------------------------
module dqdm_ctrl import dqdm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.func inside {FUNC_APPEND, FUNC_PREPEND}) begin
               cmd.pend_load = 1'b1;
               state_in      = ST_DELIVER;
               if (sts.full) begin
                  cmd.status = STATUS_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.status = STATUS_DONE;
               end
            end else if (sts.func == FUNC_DEL_MIN) begin
               if (sts.empty) begin
                  cmd.pend_load = 1'b1;
                  cmd.status    = STATUS_EMPTY;
                  state_in      = ST_DELIVER;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else begin
               // unused code: report the count unchanged
               cmd.pend_load = 1'b1;
               cmd.status    = STATUS_DONE;
               state_in      = ST_DELIVER;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (!sts.scan_more) begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (sts.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end else begin
               cmd.remove    = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.use_best  = 1'b1;
               cmd.status    = STATUS_DONE;
               state_in      = ST_DELIVER;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_DELIVER: begin
            // hold until the response register is free
            if (sts.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/deque_with_delete_min.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_delete_min: bounded deque of signed words with delete-min
// Append at the back, prepend at the front, or remove the smallest entry
// (nearest the front on a tie). Every request returns one response.
//
//   channel   direction   ports                               contents
//   req       in          req_valid req_ready req_payload     func, value
//   rsp       out         rsp_valid rsp_ready rsp_payload     status,
//                                                             removed_value,
//                                                             entry_total
//
// Append, prepend, rejected insert and unused codes pass through the execute
// and deliver states. Delete-min runs a read sweep over all entries of the
// entry memory, then one read and one write per entry moved forward.
// Synchronous reset empties the store; the memory itself is not cleared.
// A stalled response holds the sequencer until the response register frees.
// ----------------------------------------------------------------------------
module deque_with_delete_min import dqdm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   dqdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dqdm_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/deque_with_delete_min_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_delete_min_tb: self-checking bench for the delete-min deque
// Directed requests hit the empty, full, tie and unused-code cases, then
// random requests with biased insert/delete mix walk the fill level up and
// down. A shadow deque predicts every response; a monitor compares each
// field in order while both channels stall in random bursts.
// ----------------------------------------------------------------------------
module deque_with_delete_min_tb;
   import dqdm_pkg::*;

   localparam int DEPTH        = CAPACITY_DEF;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_OPS   = 500;
   localparam int TAIL_OPS     = 40;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 80;
   // watchdog limit, sized for the slowest case of ~525 requests
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   req_type                   queued_reqs[$];
   rsp_type                   pending_rsps[$];
   logic signed [VALUE_W-1:0] stored_values[$];

   int cycle_count    = 0;
   int total_reqs     = 0;
   int accepted_count = 0;
   int rsp_count      = 0;
   int fault_count    = 0;
   int req_gap        = 0;
   int rsp_gap        = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   deque_with_delete_min #(
      .CAPACITY(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Apply one request to the shadow deque and return the response it yields.
   function automatic rsp_type predict_deque_op(req_type r);
      rsp_type res;
      int      pos;
      res        = '0;
      res.status = STATUS_DONE;
      case (r.func)
         FUNC_APPEND, FUNC_PREPEND: begin
            if (stored_values.size() >= DEPTH) begin
               res.status = STATUS_FULL;
            end else if (r.func == FUNC_APPEND) begin
               stored_values.push_back(r.value);
            end else begin
               stored_values.push_front(r.value);
            end
         end
         FUNC_DEL_MIN: begin
            if (stored_values.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               pos = 0;
               // strict compare keeps the frontmost of equal minima
               for (int i = 1; i < stored_values.size(); i++) begin
                  if (stored_values[i] < stored_values[pos]) pos = i;
               end
               res.removed_value = stored_values[pos];
               stored_values.delete(pos);
            end
         end
         default: begin
         end
      endcase
      res.entry_total = TOTAL_W'(stored_values.size());
      return res;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:             return VAL_MIN;
         1:             return VAL_MAX;
         2:             return '0;
         3:             return -1;
         4, 5, 6, 7, 8: return 32'($urandom_range(0, 8)) - 32'd4;
         default:       return $urandom;
      endcase
   endfunction

   function automatic int idle_rate();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 50;
      endcase
   endfunction

   task automatic queue_req(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] value);
      req_type r;
      r.func  = func;
      r.value = value;
      queued_reqs.push_back(r);
      total_reqs++;
   endtask

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (pending_rsps.size() == 0) begin
         note_fault($sformatf("unexpected response status=%0d removed=%0d total=%0d",
                              got.status, got.removed_value, got.entry_total));
         return;
      end
      want = pending_rsps.pop_front();
      if (got.status !== want.status)
         note_fault($sformatf("status mismatch: expected %0d got %0d",
                              want.status, got.status));
      if (got.removed_value !== want.removed_value)
         note_fault($sformatf("removed_value mismatch: expected %0d got %0d",
                              want.removed_value, got.removed_value));
      if (got.entry_total !== want.entry_total)
         note_fault($sformatf("entry_total mismatch: expected %0d got %0d",
                              want.entry_total, got.entry_total));
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            pending_rsps.push_back(predict_deque_op(req_payload));
            accepted_count <= accepted_count + 1;
         end
         if (cycle_count % 64 == 0) req_idle_pct <= idle_rate();
         // hold valid and payload until the request is taken
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (queued_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (queued_reqs.size() >= TAIL_OPS && hold_left == 0 &&
                         $urandom_range(0, 99) < req_idle_pct) begin
               req_valid <= 1'b0;
               req_gap   <= $urandom_range(0, 11);
            end else begin
               req_valid   <= 1'b1;
               req_payload <= queued_reqs.pop_front();
            end
         end
      end
   end

   // Response monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_response(rsp_payload);
            rsp_count <= rsp_count + 1;
         end
         if (cycle_count % 64 == 32) rsp_idle_pct <= idle_rate();
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            // long back-pressure: block must stall its request side
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (rsp_gap != 0) begin
            rsp_ready <= 1'b0;
            rsp_gap   <= rsp_gap - 1;
         end else if (queued_reqs.size() >= TAIL_OPS &&
                      $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            rsp_gap   <= $urandom_range(0, 11);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL deque_with_delete_min");
      $finish;
   end

   initial begin
      int counted;
      int insert_pct;
      int roll;

      // empty store, unused code, extremes, ties on the minimum
      queue_req(FUNC_DEL_MIN, pick_value());
      queue_req(FUNC_UNUSED, $urandom);
      queue_req(FUNC_APPEND, VAL_MAX);
      queue_req(FUNC_PREPEND, VAL_MIN);
      queue_req(FUNC_APPEND, VAL_MIN);
      queue_req(FUNC_APPEND, -1);
      queue_req(FUNC_PREPEND, 32'sd5);
      queue_req(FUNC_DEL_MIN, '0);
      queue_req(FUNC_DEL_MIN, -1);
      // fill to capacity, then inserts must be rejected
      for (int i = 0; i < DEPTH - 3; i++) begin
         queue_req((i % 2) ? FUNC_PREPEND : FUNC_APPEND, pick_value());
      end
      queue_req(FUNC_APPEND, $urandom);
      queue_req(FUNC_PREPEND, $urandom);
      queue_req(FUNC_UNUSED, $urandom);

      counted    = 0;
      insert_pct = 50;
      while (counted < RANDOM_OPS) begin
         if (counted % 40 == 0) begin
            case ($urandom_range(0, 4))
               0:       insert_pct = 90;
               1:       insert_pct = 70;
               2:       insert_pct = 50;
               3:       insert_pct = 30;
               default: insert_pct = 10;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            queue_req(FUNC_UNUSED, $urandom);
         end else begin
            if ($urandom_range(0, 99) < insert_pct) begin
               queue_req($urandom_range(0, 1) ? FUNC_PREPEND : FUNC_APPEND, pick_value());
            end else begin
               queue_req(FUNC_DEL_MIN, $urandom);
            end
            counted++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_reqs || pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_rsps.size() != 0)
         note_fault($sformatf("%0d responses never arrived", pending_rsps.size()));
      if (fault_count == 0) begin
         $display("PASS deque_with_delete_min");
      end else begin
         $display("FAIL deque_with_delete_min");
      end
      $finish;
   end

endmodule

// ===== deque_with_delete_min.f =====
rtl/dqdm_pkg.sv
rtl/dqdm_dpath.sv
rtl/dqdm_ctrl.sv
rtl/deque_with_delete_min.sv
dv/deque_with_delete_min_tb.sv
